### rtl/core/drs_pkg.sv
// Shared types, status codes and constants for the directory record store.
package drs_pkg;

   // Default sizes of the record store and of one name.
   localparam int STORE_BYTES_DEFAULT    = 4096;
   localparam int MAX_NAME_BYTES_DEFAULT = 255;

   // A record header is four inode bytes and one length byte.
   localparam int HDR_BYTES = 5;
   localparam int LEN_W     = 8;
   localparam logic [LEN_W-1:0] LEN_MASK = 8'hFF;

   // Name opcodes.
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_INVALID   = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // One finished name, handed from the front end to the back end.
   typedef struct packed {
      logic             op;
      logic [LEN_W-1:0] len;
      logic             ovf;
      logic [31:0]      inode;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_APPEND,
      BK_WALK,
      BK_LEN_CHK,
      BK_CMP_RD,
      BK_CMP_CHK,
      BK_INO_RD,
      BK_INO_CHK
   } back_state_type;

endpackage

### rtl/core/drs_ram.sv
// Generic single write port, single read port RAM with registered read.
module drs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/drs_front.sv
// Front end: accepts name bytes, stages them and hands finished names on.
module drs_front import drs_pkg::*; #(
   parameter int STORE_BYTES    = STORE_BYTES_DEFAULT,
   parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEFAULT,
   parameter int UW             = $clog2(STORE_BYTES + 1),
   parameter int AW             = $clog2(STORE_BYTES),
   parameter int QAW            = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           req_opcode,
   input  logic [31:0]    req_entry_inode,
   input  logic [7:0]     req_name_byte,
   input  logic           req_byte_present,
   input  logic           req_last_byte,
   input  logic [UW-1:0]  used_bytes,
   output logic           rec_wr_en,
   output logic [AW-1:0]  rec_wr_addr,
   output logic [7:0]     rec_wr_data,
   output logic           q_wr_en,
   output logic [QAW-1:0] q_wr_addr,
   output logic [7:0]     q_wr_data,
   output logic           push,
   output cmd_type        push_cmd
);

   logic             open_ff, open_in;
   logic             op_ff, op_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [31:0]      inode_ff, inode_in;

   logic             cur_op;
   logic [LEN_W-1:0] cur_len;
   logic             cur_ovf;
   logic [31:0]      cur_inode;
   logic [UW:0]      pos;
   logic             room;

   // The first transaction of a name opens it and samples opcode and inode.
   always_comb begin
      cur_op    = open_ff ? op_ff    : req_opcode;
      cur_len   = open_ff ? len_ff   : '0;
      cur_ovf   = open_ff ? ovf_ff   : 1'b0;
      cur_inode = open_ff ? inode_ff : req_entry_inode;
      pos = (UW+1)'(used_bytes) + (UW+1)'(HDR_BYTES) + (UW+1)'(cur_len);
      room = (cur_len < LEN_W'(MAX_NAME_BYTES));

      open_in  = open_ff;
      op_in    = op_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      inode_in = inode_ff;
      rec_wr_en = 1'b0;
      q_wr_en   = 1'b0;
      push      = 1'b0;

      if (accept) begin
         open_in  = ~req_last_byte;
         op_in    = cur_op;
         len_in   = cur_len;
         ovf_in   = cur_ovf;
         inode_in = cur_inode;
         if (req_byte_present) begin
            if (room) begin
               len_in = cur_len + LEN_W'(1);
               if (cur_op == OP_APPEND) begin
                  rec_wr_en = (pos < (UW+1)'(STORE_BYTES));
               end else begin
                  q_wr_en = 1'b1;
               end
            end else begin
               ovf_in = 1'b1;
            end
         end
         push = req_last_byte;
      end

      rec_wr_addr = pos[AW-1:0];
      rec_wr_data = req_name_byte;
      q_wr_addr   = cur_len[QAW-1:0];
      q_wr_data   = req_name_byte;
      push_cmd.op    = cur_op;
      push_cmd.len   = len_in;
      push_cmd.ovf   = ovf_in;
      push_cmd.inode = cur_inode;
   end

   // Name staging registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         op_ff    <= 1'b0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         inode_ff <= '0;
      end else begin
         open_ff  <= open_in;
         op_ff    <= op_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         inode_ff <= inode_in;
      end
   end

endmodule

### rtl/core/drs_queue.sv
// Two-entry command queue between the front end and the back end.
module drs_queue import drs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   // Pointer and fill count update.
   always_comb begin
      do_push   = push && (count_ff != 2'd2);
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

endmodule

### rtl/core/drs_back.sv
// Back end: commits appends and walks the record store for lookups.
module drs_back import drs_pkg::*; #(
   parameter int STORE_BYTES    = STORE_BYTES_DEFAULT,
   parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEFAULT,
   parameter int UW             = $clog2(STORE_BYTES + 1),
   parameter int AW             = $clog2(STORE_BYTES),
   parameter int QAW            = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           cmd_valid,
   input  cmd_type        cmd,
   output logic           cmd_pop,
   output logic           active,
   output logic [UW-1:0]  used_bytes,
   output logic           hdr_wr_en,
   output logic [AW-1:0]  hdr_wr_addr,
   output logic [7:0]     hdr_wr_data,
   output logic [AW-1:0]  rec_rd_addr,
   input  logic [7:0]     rec_rd_data,
   output logic [QAW-1:0] q_rd_addr,
   input  logic [7:0]     q_rd_data,
   output logic           rsp_valid,
   output logic [2:0]     rsp_status,
   output logic [31:0]    rsp_found_inode
);

   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [UW-1:0]    used_ff, used_in;
   logic             valid_ff, valid_in;
   logic [UW-1:0]    loc_ff, loc_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [31:0]      inode_ff, inode_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_inode_ff, rsp_inode_in;

   logic [UW-1:0]    remain;
   logic [UW:0]      size;
   logic [UW:0]      rec_end;
   logic [UW:0]      next_loc;
   logic [UW:0]      rd_addr;

   // Size checks and the address of the current read.
   always_comb begin
      remain   = UW'(STORE_BYTES) - used_ff;
      size     = (UW+1)'(cmd_ff.len) + (UW+1)'(HDR_BYTES);
      rec_end  = (UW+1)'(loc_ff) + size;
      next_loc = (UW+1)'(loc_ff) + (UW+1)'(HDR_BYTES) + (UW+1)'(rec_rd_data);
      unique case (state_ff)
         BK_CMP_RD: rd_addr = rec_end - (UW+1)'(cmd_ff.len) + (UW+1)'(idx_ff);
         BK_INO_RD: rd_addr = (UW+1)'(loc_ff) + (UW+1)'(idx_ff);
         default:   rd_addr = (UW+1)'(loc_ff) + (UW+1)'(HDR_BYTES - 1);
      endcase
      rec_rd_addr = rd_addr[AW-1:0];
      q_rd_addr   = idx_ff[QAW-1:0];
   end

   // Sequencer for commits and the record walk.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      used_in       = used_ff;
      valid_in      = valid_ff;
      loc_in        = loc_ff;
      idx_in        = idx_ff;
      inode_in      = inode_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_inode_in  = rsp_inode_ff;
      cmd_pop       = 1'b0;
      hdr_wr_en     = 1'b0;
      hdr_wr_addr   = AW'((UW+1)'(used_ff) + (UW+1)'(idx_ff));
      unique case (idx_ff[2:0])
         3'd0:    hdr_wr_data = cmd_ff.inode[7:0];
         3'd1:    hdr_wr_data = cmd_ff.inode[15:8];
         3'd2:    hdr_wr_data = cmd_ff.inode[23:16];
         3'd3:    hdr_wr_data = cmd_ff.inode[31:24];
         default: hdr_wr_data = cmd_ff.len & LEN_MASK;
      endcase

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               idx_in  = '0;
               loc_in  = '0;
               if (cmd.op == OP_APPEND) begin
                  state_in = BK_APPEND;
               end else begin
                  state_in = BK_WALK;
               end
            end
         end
         BK_APPEND: begin
            // Failures leave the store untouched; otherwise write the header.
            if (cmd_ff.ovf) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_TOO_LARGE;
               rsp_inode_in  = '0;
               state_in      = BK_IDLE;
            end else if (size > (UW+1)'(remain)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_inode_in  = '0;
               state_in      = BK_IDLE;
            end else begin
               hdr_wr_en = 1'b1;
               idx_in    = idx_ff + LEN_W'(1);
               if (idx_ff == LEN_W'(HDR_BYTES - 1)) begin
                  used_in       = UW'((UW+1)'(used_ff) + size);
                  valid_in      = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_inode_in  = '0;
                  state_in      = BK_IDLE;
               end
            end
         end
         BK_WALK: begin
            // The length byte of the record at loc is being read.
            rsp_inode_in = '0;
            if (!valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_INVALID;
               state_in      = BK_IDLE;
            end else if (cmd_ff.ovf || (loc_ff >= used_ff) ||
                         (rec_end > (UW+1)'(used_ff))) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               state_in      = BK_IDLE;
            end else begin
               state_in = BK_LEN_CHK;
            end
         end
         BK_LEN_CHK: begin
            idx_in = '0;
            if (rec_rd_data != cmd_ff.len) begin
               loc_in   = next_loc[UW-1:0];
               state_in = BK_WALK;
            end else if (cmd_ff.len == '0) begin
               state_in = BK_INO_RD;
            end else begin
               state_in = BK_CMP_RD;
            end
         end
         BK_CMP_RD: begin
            state_in = BK_CMP_CHK;
         end
         BK_CMP_CHK: begin
            if (rec_rd_data != q_rd_data) begin
               loc_in   = rec_end[UW-1:0];
               state_in = BK_WALK;
            end else if (idx_ff == cmd_ff.len - LEN_W'(1)) begin
               idx_in   = '0;
               state_in = BK_INO_RD;
            end else begin
               idx_in   = idx_ff + LEN_W'(1);
               state_in = BK_CMP_RD;
            end
         end
         BK_INO_RD: begin
            state_in = BK_INO_CHK;
         end
         BK_INO_CHK: begin
            // Inode bytes come least significant first.
            unique case (idx_ff[1:0])
               2'd0: inode_in[7:0]   = rec_rd_data;
               2'd1: inode_in[15:8]  = rec_rd_data;
               2'd2: inode_in[23:16] = rec_rd_data;
               2'd3: inode_in[31:24] = rec_rd_data;
            endcase
            if (idx_ff[1:0] == 2'd3) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_inode_in  = {rec_rd_data, inode_ff[23:0]};
               state_in      = BK_IDLE;
            end else begin
               idx_in   = idx_ff + LEN_W'(1);
               state_in = BK_INO_RD;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         used_ff       <= '0;
         valid_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_inode_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_inode_ff  <= rsp_inode_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      loc_ff   <= loc_in;
      idx_ff   <= idx_in;
      inode_ff <= inode_in;
   end

   assign active          = (state_ff != BK_IDLE);
   assign used_bytes      = used_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_inode = rsp_inode_ff;

endmodule

### rtl/core/directory_record_store_core.sv
// Top level of the directory record store.
// Name bytes are taken one per cycle while busy is low. The transaction that
// carries the last mark hands the name to the back end and busy rises until
// its result strobe. An append writes five header bytes over the single
// record memory write port, or none when it fails. A lookup walks the
// records; for each it reads the length byte, on a length match compares
// the name bytes one at a time, and on a full match reads the four inode
// bytes, all through the one registered read port of the record memory.
// The result strobe lasts one cycle and cannot be held off; a new name may
// start in the cycle in which the previous result is shown.
module directory_record_store_core import drs_pkg::*; #(
   parameter int STORE_BYTES    = STORE_BYTES_DEFAULT,
   parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [31:0] req_entry_inode,
   input  logic [7:0]  req_name_byte,
   input  logic        req_byte_present,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_found_inode
);

   localparam int UW  = $clog2(STORE_BYTES + 1);
   localparam int AW  = $clog2(STORE_BYTES);
   localparam int QAW = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

   logic           accept;
   logic [UW-1:0]  used_bytes;
   logic           f_wr_en, h_wr_en, q_wr_en;
   logic [AW-1:0]  f_wr_addr, h_wr_addr, rec_rd_addr, rec_wr_addr;
   logic [7:0]     f_wr_data, h_wr_data, rec_rd_data, q_wr_data, q_rd_data, rec_wr_data;
   logic [QAW-1:0] q_wr_addr, q_rd_addr;
   logic           push, pop, not_empty, active;
   cmd_type        push_cmd, head;

   assign busy   = not_empty || active;
   assign accept = start && !busy;

   drs_front #(.STORE_BYTES(STORE_BYTES), .MAX_NAME_BYTES(MAX_NAME_BYTES)) u_front (
      .clock, .reset, .accept, .req_opcode, .req_entry_inode, .req_name_byte,
      .req_byte_present, .req_last_byte, .used_bytes,
      .rec_wr_en(f_wr_en), .rec_wr_addr(f_wr_addr), .rec_wr_data(f_wr_data),
      .q_wr_en, .q_wr_addr, .q_wr_data, .push, .push_cmd
   );

   drs_queue u_queue (
      .clock, .reset, .push, .push_cmd, .pop, .not_empty, .head
   );

   drs_back #(.STORE_BYTES(STORE_BYTES), .MAX_NAME_BYTES(MAX_NAME_BYTES)) u_back (
      .clock, .reset, .cmd_valid(not_empty), .cmd(head), .cmd_pop(pop), .active,
      .used_bytes, .hdr_wr_en(h_wr_en), .hdr_wr_addr(h_wr_addr), .hdr_wr_data(h_wr_data),
      .rec_rd_addr, .rec_rd_data, .q_rd_addr, .q_rd_data,
      .rsp_valid, .rsp_status, .rsp_found_inode
   );

   // The front end writes name bytes only while the back end is idle.
   assign rec_wr_addr = h_wr_en ? h_wr_addr : f_wr_addr;
   assign rec_wr_data = h_wr_en ? h_wr_data : f_wr_data;

   drs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_record_ram (
      .clock, .wr_en(h_wr_en || f_wr_en), .wr_addr(rec_wr_addr), .wr_data(rec_wr_data),
      .rd_addr(rec_rd_addr), .rd_data(rec_rd_data)
   );

   drs_ram #(.WIDTH(8), .DEPTH(MAX_NAME_BYTES)) u_query_ram (
      .clock, .wr_en(q_wr_en), .wr_addr(q_wr_addr), .wr_data(q_wr_data),
      .rd_addr(q_rd_addr), .rd_data(q_rd_data)
   );

endmodule

### rtl/core/drs_checker.sv
// Port-level checker for the directory record store, bound to the top level.
module drs_checker import drs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_found_inode
);

   // A failed result never carries an inode.
   a_inode_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_found_inode == '0)
      else $error("inode reported with a failing status");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_FULL))
      else $error("undefined status code");

   // Closing a name makes the block busy until its result.
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_byte |=> busy)
      else $error("not busy after a closing transaction");

   // A result strobe is never directly followed by another.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // A result only appears while a name was being processed.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy))
      else $error("result without work in progress");

endmodule

bind directory_record_store_core drs_checker u_drs_checker (
   .clock, .reset, .start, .busy, .req_last_byte,
   .rsp_valid, .rsp_status, .rsp_found_inode
);
